>>> hdl/slir_pkg.sv
package slir_pkg;

  localparam int unsigned LEN_W  = 5;
  localparam int unsigned ID_W   = 7;
  localparam int unsigned KIND_W = 2;

  localparam logic [7:0] ID_LOW  = 8'h30;
  localparam logic [7:0] ID_HIGH = 8'h50;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;

  localparam logic [ID_W-1:0] LOCK_COUNT   = 7'd100;
  localparam logic [ID_W-1:0] RST_OWN_ID   = 7'h30;
  localparam logic [ID_W-1:0] RST_NEXT_ID  = 7'h32;

  localparam logic [KIND_W-1:0] KIND_ECHO   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  typedef struct packed {
    logic take_item;
    logic send_line;
  } cmd_t;

  typedef struct packed {
    logic role;
    logic is_term;
    logic fill_empty;
    logic fill_full;
    logic last_byte;
  } status_t;

endpackage

>>> hdl/serial_line_and_id_receiver.sv
// Serial line and chain id receiver. Each received byte is one request on the
// in_ channel. With cfg_role at 0 (master) a byte other than CR or LF is kept in
// a line store of LINE_SIZE-1 bytes and echoed; bytes past a full store are
// dropped with no result. CR or LF on a non-empty store plays the whole line out
// as line results, the last flagged, each carrying the length, and empties the
// store; on an empty store it gives nothing. With cfg_role at 1 (slave) every
// byte gives one status result with the learned id, the next id and the lock
// flag. Echo and status requests may follow one another back to back while
// out_stall is low. A line end keeps in_stall high while the store, a memory
// with a registered read port, is walked one byte per read-then-send pair, and
// longer while out_stall holds a send. Write cfg_role only while idle.
module serial_line_and_id_receiver
  import slir_pkg::*;
#(
  parameter int unsigned LINE_SIZE = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_role,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] out_result_kind,
  output logic [7:0]        out_data_byte,
  output logic              out_last_of_line,
  output logic [LEN_W-1:0]  out_line_length,
  output logic [ID_W-1:0]   out_own_id,
  output logic [ID_W-1:0]   out_following_id,
  output logic              out_id_locked
);

  cmd_t    cmd;
  status_t stat;

  slir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  slir_dpath #(
    .LINE_SIZE (LINE_SIZE)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_role),
    .rx_byte      (in_rx_byte),
    .cmd          (cmd),
    .stat         (stat),
    .result_kind  (out_result_kind),
    .data_byte    (out_data_byte),
    .last_of_line (out_last_of_line),
    .line_length  (out_line_length),
    .own_id       (out_own_id),
    .following_id (out_following_id),
    .id_locked    (out_id_locked)
  );

endmodule

>>> hdl/slir_ctrl.sv
module slir_ctrl
  import slir_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t stat,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   in_acc;
  logic   emit_item;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  assign emit_item = stat.role || (!stat.is_term && !stat.fill_full);

  always_comb begin
    state_nxt     = state_r;
    cmd.take_item = 1'b0;
    cmd.send_line = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.take_item = 1'b1;
          if (emit_item) begin
            out_valid_nxt = 1'b1;
          end else if (stat.is_term && !stat.fill_empty) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_free) begin
          cmd.send_line = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = stat.last_byte ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/slir_dpath.sv
module slir_dpath
  import slir_pkg::*;
#(
  parameter int unsigned LINE_SIZE = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic [7:0]        rx_byte,
  input  cmd_t              cmd,
  output status_t           stat,
  output logic [KIND_W-1:0] result_kind,
  output logic [7:0]        data_byte,
  output logic              last_of_line,
  output logic [LEN_W-1:0]  line_length,
  output logic [ID_W-1:0]   own_id,
  output logic [ID_W-1:0]   following_id,
  output logic              id_locked
);

  localparam int unsigned DEPTH = LINE_SIZE - 1;
  localparam int unsigned CNT_W = $clog2(LINE_SIZE);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [7:0] line_mem [DEPTH];
  logic [7:0] rdata_r;

  logic             role_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [ID_W-1:0]  cur_id_r, cur_id_nxt;
  logic [ID_W-1:0]  next_id_r, next_id_nxt;
  logic [ID_W-1:0]  match_r, match_nxt;
  logic             conf_r, conf_nxt;

  logic [KIND_W-1:0] kind_r;
  logic [7:0]        data_r;
  logic              last_r;
  logic [LEN_W-1:0]  len_r;
  logic [ID_W-1:0]   own_r;
  logic [ID_W-1:0]   follow_r;
  logic              locked_r;

  logic store_wr;
  logic id_in_range;

  assign stat.role       = role_r;
  assign stat.is_term    = (rx_byte == CH_LF) || (rx_byte == CH_CR);
  assign stat.fill_empty = (fill_r == '0);
  assign stat.fill_full  = (fill_r == FULL_CNT);
  assign stat.last_byte  = ((ptr_r + CNT_W'(1)) == fill_r);

  assign store_wr    = cmd.take_item && !role_r && !stat.is_term && !stat.fill_full;
  assign id_in_range = (rx_byte > ID_LOW) && (rx_byte < ID_HIGH);

  always_comb begin
    fill_nxt    = fill_r;
    ptr_nxt     = ptr_r;
    cur_id_nxt  = cur_id_r;
    next_id_nxt = next_id_r;
    match_nxt   = match_r;
    conf_nxt    = conf_r;
    if (store_wr) begin
      fill_nxt = fill_r + CNT_W'(1);
    end
    if (cmd.take_item) begin
      ptr_nxt = '0;
    end
    if (cmd.send_line) begin
      ptr_nxt = ptr_r + CNT_W'(1);
      if (stat.last_byte) begin
        fill_nxt = '0;
      end
    end
    if (cmd.take_item && role_r && !conf_r && id_in_range) begin
      if (cur_id_r == rx_byte[ID_W-1:0]) begin
        if (match_r >= LOCK_COUNT) begin
          conf_nxt = 1'b1;
        end else begin
          match_nxt = match_r + ID_W'(1);
        end
      end else begin
        cur_id_nxt  = rx_byte[ID_W-1:0];
        next_id_nxt = rx_byte[ID_W-1:0] + ID_W'(2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r    <= 1'b0;
      fill_r    <= '0;
      ptr_r     <= '0;
      cur_id_r  <= RST_OWN_ID;
      next_id_r <= RST_NEXT_ID;
      match_r   <= '0;
      conf_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        role_r <= cfg_wr_data;
      end
      fill_r    <= fill_nxt;
      ptr_r     <= ptr_nxt;
      cur_id_r  <= cur_id_nxt;
      next_id_r <= next_id_nxt;
      match_r   <= match_nxt;
      conf_r    <= conf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      line_mem[fill_r[IDX_W-1:0]] <= rx_byte;
    end
    rdata_r <= line_mem[ptr_r[IDX_W-1:0]];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.send_line) begin
      kind_r   <= KIND_LINE;
      data_r   <= rdata_r;
      last_r   <= stat.last_byte;
      len_r    <= LEN_W'(fill_r);
      own_r    <= '0;
      follow_r <= '0;
      locked_r <= 1'b0;
    end else if (cmd.take_item) begin
      if (role_r) begin
        kind_r   <= KIND_STATUS;
        data_r   <= '0;
        own_r    <= cur_id_nxt;
        follow_r <= next_id_nxt;
        locked_r <= conf_nxt;
      end else begin
        kind_r   <= KIND_ECHO;
        data_r   <= rx_byte;
        own_r    <= '0;
        follow_r <= '0;
        locked_r <= 1'b0;
      end
      last_r <= 1'b0;
      len_r  <= '0;
    end
  end

  assign result_kind  = kind_r;
  assign data_byte    = data_r;
  assign last_of_line = last_r;
  assign line_length  = len_r;
  assign own_id       = own_r;
  assign following_id = follow_r;
  assign id_locked    = locked_r;

endmodule

>>> tb/rx_line_id_checker.sv
module rx_line_id_checker
  import slir_pkg::*;
#(
  parameter int unsigned LINE_SIZE = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_role,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [KIND_W-1:0] out_result_kind,
  input  logic [7:0]        out_data_byte,
  input  logic              out_last_of_line,
  input  logic [LEN_W-1:0]  out_line_length,
  input  logic [ID_W-1:0]   out_own_id,
  input  logic [ID_W-1:0]   out_following_id,
  input  logic              out_id_locked,
  output int unsigned       fail_count,
  output int unsigned       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [7:0]        data;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [ID_W-1:0]   own;
    logic [ID_W-1:0]   follow;
    logic              locked;
  } rx_result_t;

  rx_result_t       awaited_results[$];
  rx_result_t       got;
  rx_result_t       want;
  logic [7:0]       line_buf [LINE_SIZE-1];
  int unsigned      fill_level;
  logic             slave_role;
  logic [ID_W-1:0]  own_id;
  logic [ID_W-1:0]  next_id;
  logic [ID_W-1:0]  repeat_count;
  logic             id_locked;

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  task automatic absorb_rx_byte(input logic [7:0] b);
    rx_result_t r;
    r = '0;
    if (!slave_role) begin
      if (b == CH_LF || b == CH_CR) begin
        for (int unsigned k = 0; k < fill_level; k++) begin
          r.kind = KIND_LINE;
          r.data = line_buf[k];
          r.last = (k + 1 == fill_level);
          r.len = fill_level[LEN_W-1:0];
          awaited_results.push_back(r);
        end
        fill_level = 0;
      end else if (fill_level < LINE_SIZE - 1) begin
        line_buf[fill_level] = b;
        fill_level++;
        r.kind = KIND_ECHO;
        r.data = b;
        awaited_results.push_back(r);
      end
    end else begin
      if (!id_locked && b > ID_LOW && b < ID_HIGH) begin
        if ({1'b0, own_id} == b) begin
          if (repeat_count >= LOCK_COUNT) begin
            id_locked = 1'b1;
          end else begin
            repeat_count++;
          end
        end else begin
          own_id = b[ID_W-1:0];
          next_id = b[ID_W-1:0] + ID_W'(2);
        end
      end
      r.kind = KIND_STATUS;
      r.own = own_id;
      r.follow = next_id;
      r.locked = id_locked;
      awaited_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      slave_role = 1'b0;
      fill_level = 0;
      own_id = RST_OWN_ID;
      next_id = RST_NEXT_ID;
      repeat_count = '0;
      id_locked = 1'b0;
      awaited_results.delete();
    end else begin
      if (cfg_wr_en) begin
        slave_role = cfg_role;
      end
      if (in_valid && !in_stall) begin
        absorb_rx_byte(in_rx_byte);
      end
      if (out_valid && !out_stall) begin
        got = '{out_result_kind, out_data_byte, out_last_of_line, out_line_length,
                out_own_id, out_following_id, out_id_locked};
        if (awaited_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected result, expected none, actual kind %0h data %0h",
                   $time, got.kind, got.data);
        end else begin
          want = awaited_results.pop_front();
          check_field("result_kind", 8'(want.kind), 8'(got.kind));
          check_field("data_byte", want.data, got.data);
          check_field("last_of_line", 8'(want.last), 8'(got.last));
          check_field("line_length", 8'(want.len), 8'(got.len));
          check_field("own_id", 8'(want.own), 8'(got.own));
          check_field("following_id", 8'(want.follow), 8'(got.follow));
          check_field("id_locked", 8'(want.locked), 8'(got.locked));
        end
      end
    end
    outstanding <= awaited_results.size();
  end

endmodule

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import slir_pkg::*;

  localparam int unsigned LINE_SIZE = 32;
  localparam logic ROLE_MASTER = 1'b0;
  localparam logic ROLE_SLAVE = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned ITEM_TARGET = 320;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_role = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KIND_W-1:0] out_result_kind;
  logic [7:0]        out_data_byte;
  logic              out_last_of_line;
  logic [LEN_W-1:0]  out_line_length;
  logic [ID_W-1:0]   out_own_id;
  logic [ID_W-1:0]   out_following_id;
  logic              out_id_locked;
  int unsigned       fail_count;
  int unsigned       outstanding;

  logic        start_hold = 1'b0;
  int unsigned hold_left = 0;
  int unsigned recv_idle_pct = 61;
  int unsigned send_idle_pct = 35;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  logic [7:0]  slave_id = 8'h31;
  logic        cur_role = ROLE_MASTER;

  serial_line_and_id_receiver #(.LINE_SIZE(LINE_SIZE)) uut (.*);

  rx_line_id_checker #(.LINE_SIZE(LINE_SIZE)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("serial_line_and_id_receiver verification failed");
    $finish;
  end

  // result side: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (start_hold) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_id_byte(input logic [7:0] b);
    if (b > ID_LOW && b < ID_HIGH) begin
      slave_id = b;
    end
    send_byte(b);
  endtask

  // wait until every request has produced its results
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_role(input logic role);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_role <= role;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_role = role;
  endtask

  task automatic pick_idling();
    if (items_sent < 130) begin
      send_idle_pct = 35;
      recv_idle_pct <= 61;
    end else if (items_sent < 240) begin
      send_idle_pct = 61;
      recv_idle_pct <= 35;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct <= 0;
    end
  endtask

  task automatic send_lines();
    int unsigned n_lines;
    int unsigned len;
    logic [7:0]  b;
    n_lines = $urandom_range(1, 3);
    for (int unsigned i = 0; i < n_lines; i++) begin
      if ($urandom_range(5) == 0) begin
        len = LINE_SIZE - 1 + $urandom_range(3);
      end else begin
        len = $urandom_range(1, 8);
      end
      for (int unsigned k = 0; k < len; k++) begin
        b = 8'($urandom_range(255));
        // mostly clean text, some stray terminators
        if ($urandom_range(9) != 0 && (b == CH_LF || b == CH_CR)) begin
          b = b ^ 8'h40;
        end
        send_byte(b);
      end
      send_byte($urandom_range(1) ? CH_CR : CH_LF);
    end
  endtask

  task automatic send_id_bytes();
    int unsigned n;
    int unsigned pick;
    logic [7:0]  b;
    n = $urandom_range(10, 30);
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        b = slave_id;
      end else if (pick < 92) begin
        b = 8'($urandom_range(8'h31, 8'h4F));
      end else begin
        b = 8'($urandom_range(255));
      end
      send_id_byte(b);
    end
  endtask

  initial begin
    logic role;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    pick_idling();
    set_role(ROLE_MASTER);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(CH_CR);
    send_byte(CH_LF);
    // partial line kept across a role change
    send_byte(8'h61);
    send_byte(8'h62);
    set_role(ROLE_SLAVE);
    send_id_byte(8'h30);
    send_id_byte(8'h50);
    send_id_byte(8'h31);
    send_id_byte(8'h31);
    send_id_byte(8'h4F);
    send_id_byte(CH_CR);
    send_id_byte(8'hFF);
    set_role(ROLE_MASTER);
    send_byte(CH_LF);

    // long result hold-off while requests keep coming
    in_valid <= 1'b0;
    start_hold <= 1'b1;
    @(posedge clk);
    start_hold <= 1'b0;
    repeat (24) send_byte(8'(8'h20 + $urandom_range(90)));
    send_byte(CH_LF);
    settle();

    while (items_sent < ITEM_TARGET) begin
      pick_idling();
      role = 1'($urandom_range(1));
      if (role != cur_role) begin
        set_role(role);
      end
      if (role == ROLE_SLAVE) begin
        send_id_bytes();
      end else begin
        send_lines();
      end
    end

    settle();
    repeat (2 * LINE_SIZE) @(posedge clk);
    if (fail_count == 0) begin
      $display("serial_line_and_id_receiver verification clean");
    end else begin
      $display("serial_line_and_id_receiver verification failed");
    end
    $finish;
  end

endmodule
